### rtl/surface_block_shade_macros.svh
// Assertion macros used by the checker file (sbs_checker.sv).
`ifndef SURFACE_BLOCK_SHADE_MACROS_SVH
`define SURFACE_BLOCK_SHADE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("surface_block_shade: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("surface_block_shade: next-cycle check failed");

`endif

### rtl/sbs_pkg.sv
`default_nettype none

package sbs_pkg;

	// Field widths
	localparam int LIGHT_W = 14;
	localparam int TEXEL_W = 8;
	localparam int POS_W   = 4;
	localparam int ROW_W   = 6;
	localparam int DITH_W  = 8;

	// Internal signed light width; holds every intermediate value exactly
	localparam int LW = 20;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MIP_LEVEL     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DITHER_ENABLE = 1'd1;

	// Brightest colormap row
	localparam logic [ROW_W-1:0] ROW_LIMIT = 6'd63;

	// Pipeline depth, used for the in-flight bound
	localparam int PIPE_DEPTH = 4;

	typedef logic signed [LW-1:0] light_t;

	// 4x4 ordered-dither matrix, row-major
	localparam logic [3:0] BAYER [16] = '{
		4'd0,  4'd8,  4'd2,  4'd10,
		4'd12, 4'd4,  4'd14, 4'd6,
		4'd3,  4'd11, 4'd1,  4'd9,
		4'd15, 4'd7,  4'd13, 4'd5
	};

	// Floor division by 2^k on two's complement
	function automatic light_t floor_shift(input light_t x, input logic [2:0] k);
		return x >>> k;
	endfunction

endpackage

`default_nettype wire

### rtl/surface_block_shade.sv
// Channel | Handshake            | Payload
// --------+----------------------+------------------------------------------------
// in      | in_valid / in_ready  | texel, light_top_left/right, light_bottom_left/
//         |                      | right, row_in_block, col_in_block
// out     | out_valid/out_ready  | colormap_address
// cfg     | cfg_write            | cfg_index, cfg_data
//
// One pixel per clock sustained while out_ready is high; each pixel passes the
// stage registers for deltas, edge lights, row step, and final light and clamp.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles fill up while a result waits on out_ready.
// arst_n clears the valid bits and both registers (mip level 0, dither off).
// Registers are read by stages 1 and 3 directly; write them only when idle.
`default_nettype none

module surface_block_shade
	import sbs_pkg::*;
(
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_write,
	input  wire [CFG_IDX_W-1:0]        cfg_index,
	input  wire [CFG_DATA_W-1:0]       cfg_data,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire [TEXEL_W-1:0]          texel,
	input  wire [LIGHT_W-1:0]          light_top_left,
	input  wire [LIGHT_W-1:0]          light_top_right,
	input  wire [LIGHT_W-1:0]          light_bottom_left,
	input  wire [LIGHT_W-1:0]          light_bottom_right,
	input  wire [POS_W-1:0]            row_in_block,
	input  wire [POS_W-1:0]            col_in_block,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic [LIGHT_W-1:0]         colormap_address
);

	// Configuration registers
	logic [1:0] mip_level_q;
	logic       dither_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mip_level_q     <= '0;
			dither_enable_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MIP_LEVEL:     mip_level_q     <= cfg_data[1:0];
				REG_DITHER_ENABLE: dither_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Derived block geometry
	logic [2:0]       shift_k;
	logic [POS_W-1:0] pos_mask;
	assign shift_k  = 3'd4 - {1'b0, mip_level_q};
	assign pos_mask = 4'hF >> mip_level_q;

	// Stage valid bits and advance enables
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;
	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: edge deltas, wrapped position, dither offset
	logic [POS_W-1:0]  row_w, col_w;
	light_t            diff_l, diff_r;
	logic [DITH_W-1:0] dith_w;

	assign row_w  = row_in_block & pos_mask;
	assign col_w  = col_in_block & pos_mask;
	assign diff_l = $signed({{(LW-LIGHT_W){1'b0}}, light_bottom_left})
		- $signed({{(LW-LIGHT_W){1'b0}}, light_top_left});
	assign diff_r = $signed({{(LW-LIGHT_W){1'b0}}, light_bottom_right})
		- $signed({{(LW-LIGHT_W){1'b0}}, light_top_right});
	assign dith_w = dither_enable_q ? {BAYER[{row_w[1:0], col_w[1:0]}], 4'b0000} : '0;

	light_t              dl_s1, dr_s1;
	logic [LIGHT_W-1:0]  tl_s1, tr_s1;
	logic [POS_W-1:0]    row_s1, cnt_s1;
	logic [DITH_W-1:0]   dith_s1;
	logic [TEXEL_W-1:0]  texel_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			dl_s1    <= floor_shift(diff_l, shift_k);
			dr_s1    <= floor_shift(diff_r, shift_k);
			tl_s1    <= light_top_left;
			tr_s1    <= light_top_right;
			row_s1   <= row_w;
			// columns left to walk from the right edge: size-1-col
			cnt_s1   <= ~col_in_block & pos_mask;
			dith_s1  <= dith_w;
			texel_s1 <= texel;
		end
	end

	// Stage 2: left and right edge lights at this row
	light_t             left_s2, right_s2;
	logic [POS_W-1:0]   cnt_s2;
	logic [DITH_W-1:0]  dith_s2;
	logic [TEXEL_W-1:0] texel_s2;
	light_t             row_ext;
	assign row_ext = $signed({{(LW-POS_W){1'b0}}, row_s1});

	always_ff @(posedge clk) begin
		if (en_s2) begin
			left_s2  <= $signed({{(LW-LIGHT_W){1'b0}}, tl_s1}) + dl_s1 * row_ext;
			right_s2 <= $signed({{(LW-LIGHT_W){1'b0}}, tr_s1}) + dr_s1 * row_ext;
			cnt_s2   <= cnt_s1;
			dith_s2  <= dith_s1;
			texel_s2 <= texel_s1;
		end
	end

	// Stage 3: step across the row
	light_t             step_s3, right_s3;
	logic [POS_W-1:0]   cnt_s3;
	logic [DITH_W-1:0]  dith_s3;
	logic [TEXEL_W-1:0] texel_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			step_s3  <= floor_shift(left_s2 - right_s2, shift_k);
			right_s3 <= right_s2;
			cnt_s3   <= cnt_s2;
			dith_s3  <= dith_s2;
			texel_s3 <= texel_s2;
		end
	end

	// Stage 4: pixel light, dither, row select and clamp
	light_t           light_w, sum_w;
	logic [ROW_W-1:0] row_sel;

	assign light_w = right_s3 + step_s3 * $signed({{(LW-POS_W){1'b0}}, cnt_s3});
	assign sum_w   = light_w + $signed({{(LW-DITH_W){1'b0}}, dith_s3});

	always_comb begin
		// negative light wraps to a large word and clamps to the top row
		priority if (sum_w[LW-1]) begin
			row_sel = ROW_LIMIT;
		end else if (sum_w[LW-2:8] > {{(LW-9-ROW_W){1'b0}}, ROW_LIMIT}) begin
			row_sel = ROW_LIMIT;
		end else begin
			row_sel = sum_w[8 +: ROW_W];
		end
	end

	logic [LIGHT_W-1:0] addr_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			addr_s4 <= {row_sel, texel_s3};
		end
	end

	assign out_valid        = v_s4;
	assign colormap_address = addr_s4;

endmodule

`default_nettype wire

### rtl/sbs_checker.sv
`default_nettype none
`include "surface_block_shade_macros.svh"

module sbs_checker
	import sbs_pkg::*;
(
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_valid,
	input wire                 in_ready,
	input wire                 out_valid,
	input wire                 out_ready,
	input wire [LIGHT_W-1:0]   colormap_address
);

	// Track items between input and output transfers
	logic [2:0] inflight_q;
	logic       in_xfer, out_xfer;
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + {2'b00, in_xfer} - {2'b00, out_xfer};
		end
	end

	// A held result keeps its value
	`SBS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(colormap_address))

	// Input stalls only when the full pipe is blocked at the output
	`SBS_ASSERT_NOW(a_stall_cause, clk, arst_n, !in_ready, out_valid && !out_ready)

	// No result without an item in flight
	`SBS_ASSERT_NOW(a_no_invent, clk, arst_n, out_valid, inflight_q != 3'd0)

	// Never more items in flight than pipeline stages
	`SBS_ASSERT_NOW(a_depth, clk, arst_n, 1'b1, inflight_q <= 3'(PIPE_DEPTH))

endmodule

bind surface_block_shade sbs_checker u_sbs_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.colormap_address (colormap_address)
);

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int LW = sbs_pkg::LIGHT_W;
	localparam int TW = sbs_pkg::TEXEL_W;
	localparam int PW = sbs_pkg::POS_W;

	localparam logic [31:0] ROW_MASK  = 32'h0000_FF00;
	localparam logic [31:0] ROW_CLAMP = {18'd0, sbs_pkg::ROW_LIMIT, 8'd0};
	localparam int unsigned MAX_SHIFT = 4;
	localparam int SETTLE_CYCLES = sbs_pkg::PIPE_DEPTH + 4;
	localparam int LONG_HOLD     = 60;
	localparam int PHASE_ITEMS   = 75;
	localparam int NUM_PHASES    = 6;
	localparam int NUM_DIRECTED  = 17;

	// ordered-dither offsets, row-major over (row & 3, col & 3)
	localparam logic [3:0] DITHER_OFFSET [16] = '{
		4'd0,  4'd8,  4'd2,  4'd10,
		4'd12, 4'd4,  4'd14, 4'd6,
		4'd3,  4'd11, 4'd1,  4'd9,
		4'd15, 4'd7,  4'd13, 4'd5
	};

	typedef struct packed {
		logic [TW-1:0] texel;
		logic [LW-1:0] top_left;
		logic [LW-1:0] top_right;
		logic [LW-1:0] bottom_left;
		logic [LW-1:0] bottom_right;
		logic [PW-1:0] row;
		logic [PW-1:0] col;
	} pixel_t;

	typedef struct packed {
		logic [1:0]    mip;
		logic          dither;
		pixel_t        px;
		logic          typed;
		logic [LW-1:0] address;
	} directed_row_t;

	// mip, dither, {texel, TL, TR, BL, BR, row, col}, typed, address
	localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		'{2'd0, 1'b0, '{8'h00, 14'd0, 14'd0, 14'd0, 14'd0, 4'd0, 4'd0}, 1'b1, 14'h0000},
		'{2'd0, 1'b0, '{8'hFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 4'd15, 4'd15},
			1'b1, 14'h3FFF},
		'{2'd0, 1'b0, '{8'h56, 14'h1234, 14'h1234, 14'h1234, 14'h1234, 4'd15, 4'd15},
			1'b1, 14'h1256},
		'{2'd0, 1'b0, '{8'hFF, 14'h0000, 14'h2A00, 14'h1111, 14'h3333, 4'd0, 4'd15},
			1'b1, 14'h2AFF},
		'{2'd0, 1'b0, '{8'h80, 14'h00FF, 14'h00FF, 14'h00FF, 14'h00FF, 4'd6, 4'd2},
			1'b1, 14'h0080},
		'{2'd0, 1'b0, '{8'h3C, 14'h0000, 14'h3FFF, 14'h3FFF, 14'h0000, 4'd15, 4'd0},
			1'b0, 14'h0000},
		'{2'd0, 1'b0, '{8'hC3, 14'h3FFF, 14'h0000, 14'h0000, 14'h3FFF, 4'd7, 4'd9},
			1'b0, 14'h0000},
		'{2'd0, 1'b0, '{8'hAA, 14'h2AAA, 14'h1555, 14'h1555, 14'h2AAA, 4'd5, 4'd10},
			1'b0, 14'h0000},
		'{2'd0, 1'b1, '{8'h80, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 4'd0, 4'd1},
			1'b1, 14'h3F80},
		'{2'd0, 1'b1, '{8'h01, 14'h0010, 14'h0010, 14'h0010, 14'h0010, 4'd3, 4'd0},
			1'b1, 14'h0101},
		'{2'd0, 1'b1, '{8'h55, 14'h0155, 14'h3EAA, 14'h2000, 14'h0800, 4'd10, 4'd5},
			1'b0, 14'h0000},
		'{2'd1, 1'b1, '{8'h0F, 14'h0100, 14'h3F00, 14'h3800, 14'h0400, 4'd7, 4'd7},
			1'b0, 14'h0000},
		'{2'd1, 1'b0, '{8'hF0, 14'h0F00, 14'h0100, 14'h3000, 14'h2200, 4'd9, 4'd12},
			1'b0, 14'h0000},
		'{2'd2, 1'b0, '{8'h99, 14'h3FFF, 14'h0000, 14'h1000, 14'h3FFF, 4'd15, 4'd15},
			1'b0, 14'h0000},
		'{2'd2, 1'b1, '{8'h66, 14'h0800, 14'h2400, 14'h1200, 14'h3600, 4'd2, 4'd3},
			1'b0, 14'h0000},
		'{2'd3, 1'b0, '{8'h11, 14'h3FFF, 14'h0A00, 14'h0000, 14'h3FFF, 4'd14, 4'd13},
			1'b1, 14'h0A11},
		'{2'd3, 1'b1, '{8'h00, 14'h0000, 14'h3FFF, 14'h3FFF, 14'h0000, 4'd15, 4'd15},
			1'b1, 14'h2000}
	};

	logic          clk;
	logic          arst_n;
	logic          cfg_write;
	logic [sbs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [sbs_pkg::CFG_DATA_W-1:0] cfg_data;
	logic          in_valid;
	logic          in_ready;
	logic [TW-1:0] texel;
	logic [LW-1:0] light_top_left;
	logic [LW-1:0] light_top_right;
	logic [LW-1:0] light_bottom_left;
	logic [LW-1:0] light_bottom_right;
	logic [PW-1:0] row_in_block;
	logic [PW-1:0] col_in_block;
	logic          out_valid;
	logic          out_ready;
	logic [LW-1:0] colormap_address;

	// register copies as the block should hold them
	logic [1:0]    mip_q;
	logic          dither_q;

	logic [LW-1:0] expected_addresses [$];
	logic [LW-1:0] oldest_address;
	int            errors;
	bit            sender_idle;
	bit            receiver_idle;
	bit            long_hold_req;
	int            stall_left;

	surface_block_shade u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.texel              (texel),
		.light_top_left     (light_top_left),
		.light_top_right    (light_top_right),
		.light_bottom_left  (light_bottom_left),
		.light_bottom_right (light_bottom_right),
		.row_in_block       (row_in_block),
		.col_in_block       (col_in_block),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.colormap_address   (colormap_address)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// floor division by a power of two on a 32-bit two's complement word
	function automatic logic [31:0] asr_floor(input logic [31:0] x, input int unsigned s);
		return $unsigned($signed(x) >>> s);
	endfunction

	// interpolate the block light, add dither, pick the clamped colormap row
	function automatic logic [LW-1:0] shade_address(input pixel_t px, input logic [1:0] mip,
			input logic dith);
		logic [31:0] size;
		logic [31:0] i;
		logic [31:0] b;
		logic [31:0] left;
		logic [31:0] right;
		logic [31:0] step;
		logic [31:0] light;
		logic [31:0] offset;
		logic [31:0] row_sel;
		int unsigned k;
		k = MAX_SHIFT - mip;
		size = 32'd16 >> mip;
		i = 32'(px.row) & (size - 32'd1);
		b = 32'(px.col) & (size - 32'd1);
		left = 32'(px.top_left) + i * asr_floor(32'(px.bottom_left) - 32'(px.top_left), k);
		right = 32'(px.top_right) + i * asr_floor(32'(px.bottom_right) - 32'(px.top_right), k);
		step = asr_floor(left - right, k);
		light = right + (size - 32'd1 - b) * step;
		offset = dith ? (32'(DITHER_OFFSET[{i[1:0], b[1:0]}]) << 4) : 32'd0;
		row_sel = (light + offset) & ROW_MASK;
		if (row_sel > ROW_CLAMP)
			row_sel = ROW_CLAMP;
		return LW'(row_sel + 32'(px.texel));
	endfunction

	// lean towards dark, saturated and near-clamp lights
	function automatic logic [LW-1:0] random_light();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return LW'($urandom_range(16'h3E00, 16'h3FFF));
			default: return LW'($urandom_range(0, 16383));
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		px.texel        = TW'($urandom_range(0, 255));
		px.top_left     = random_light();
		px.top_right    = random_light();
		px.bottom_left  = random_light();
		px.bottom_right = random_light();
		px.row          = PW'($urandom_range(0, 15));
		px.col          = PW'($urandom_range(0, 15));
		return px;
	endfunction

	task automatic write_register(input logic [sbs_pkg::CFG_IDX_W-1:0] idx,
			input logic [sbs_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		case (idx)
			sbs_pkg::REG_MIP_LEVEL:     mip_q = value;
			sbs_pkg::REG_DITHER_ENABLE: dither_q = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	// upper data bit of the dither write is noise the block must drop
	task automatic set_mode(input logic [1:0] mip, input logic dith);
		write_register(sbs_pkg::REG_MIP_LEVEL, mip);
		write_register(sbs_pkg::REG_DITHER_ENABLE, {1'($urandom_range(0, 1)), dith});
	endtask

	// drop valid, wait for every outstanding result, then let the pipe settle
	task automatic wait_for_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_addresses.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// offer one pixel and record its expected address on transfer
	task automatic send_pixel(input pixel_t px, input logic typed, input logic [LW-1:0] address);
		int gap;
		if (sender_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		texel              = px.texel;
		light_top_left     = px.top_left;
		light_top_right    = px.top_right;
		light_bottom_left  = px.bottom_left;
		light_bottom_right = px.bottom_right;
		row_in_block       = px.row;
		col_in_block       = px.col;
		in_valid           = 1'b1;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		expected_addresses.push_back(typed ? address : shade_address(px, mip_q, dither_q));
	endtask

	// compare each output transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (expected_addresses.size() == 0) begin
				$display("%0t: unexpected colormap_address, expected none, got %h",
					$time, colormap_address);
				errors++;
			end else begin
				oldest_address = expected_addresses.pop_front();
				if (colormap_address !== oldest_address) begin
					$display("%0t: colormap_address expected %h, got %h",
						$time, oldest_address, colormap_address);
					errors++;
				end
			end
		end
	end

	// receiver: random stall bursts, plus one long hold on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end
			// drop any leftover stall once the flat-out part starts
			if (!receiver_idle)
				stall_left = 0;
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				stall_left = $urandom_range(1, 18) - 1;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [1:0] phase_mip [NUM_PHASES];
		logic       phase_dither [NUM_PHASES];
		phase_mip    = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd0};
		phase_dither = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
		arst_n             = 1'b0;
		cfg_write          = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		in_valid           = 1'b0;
		texel              = '0;
		light_top_left     = '0;
		light_top_right    = '0;
		light_bottom_left  = '0;
		light_bottom_right = '0;
		row_in_block       = '0;
		col_in_block       = '0;
		mip_q              = '0;
		dither_q           = 1'b0;
		errors             = 0;
		stall_left         = 0;
		long_hold_req      = 1'b0;
		sender_idle        = 1'b1;
		receiver_idle      = 1'b1;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed rows; change mode only once the pipe has drained
		for (int r = 0; r < NUM_DIRECTED; r++) begin
			if (DIRECTED_ROWS[r].mip != mip_q || DIRECTED_ROWS[r].dither != dither_q) begin
				wait_for_results();
				set_mode(DIRECTED_ROWS[r].mip, DIRECTED_ROWS[r].dither);
			end
			send_pixel(DIRECTED_ROWS[r].px, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].address);
		end

		// random phases across the register settings; the last one runs flat out
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_for_results();
			set_mode(phase_mip[p], phase_dither[p]);
			@(posedge clk);
			sender_idle   = (p != NUM_PHASES - 1);
			receiver_idle = (p != NUM_PHASES - 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// hold the output off while input keeps coming, to back the pipe up
				if (p == 1 && n == 20) begin
					sender_idle   = 1'b0;
					long_hold_req = 1'b1;
				end
				if (p == 1 && n == 45)
					sender_idle = 1'b1;
				// pause input until the pipe is empty
				if (p == 2 && n == 37)
					wait_for_results();
				send_pixel(random_pixel(), 1'b0, '0);
			end
		end

		wait_for_results();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/sbs_pkg.sv
rtl/surface_block_shade.sv
rtl/sbs_checker.sv
verif/testbench.sv
